@@ rtl/bdv_pkg.sv @@
// bdv_pkg: types and constants shared by the beeper DC blocker / volume stage.
// No dependencies; imported by every module of the block.
package bdv_pkg;

    // Field widths
    localparam int LEVEL_W  = 8;
    localparam int DEPTH_W  = 12;
    localparam int GAIN_W   = 9;
    localparam int MEAN_W   = 16;
    localparam int DIFF_W   = MEAN_W + 1;
    localparam int MAG_W    = 8;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int DAC_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    // DC blocker shifts
    localparam int MEAN_SHIFT = 9;
    localparam int OUT_SHIFT  = 8;

    // Volume scaling by gain/320: drop 6 bits, then divide by 5 via 6554/2^15
    localparam int DIV64_SHIFT = 6;
    localparam int QUOT0_W     = PROD_W - DIV64_SHIFT;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_5 = 13'd6554;
    localparam int RECIP_SHIFT = 15;
    localparam int RPROD_W     = QUOT0_W + RECIP_W;
    localparam int QUOT_W      = RPROD_W - RECIP_SHIFT;

    // Output level
    localparam logic [LEVEL_W-1:0] MID_LEVEL = 8'd128;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 8'd255;
    localparam logic [QUOT_W-1:0]  POS_LIMIT = 9'd127;
    localparam logic [QUOT_W-1:0]  NEG_LIMIT = 9'd128;

    // Register reset values and indexes
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 9'd320;
    localparam logic [DEPTH_W-1:0] THRESH_RESET = 12'd1323;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b1;

    typedef struct packed {
        logic                have_sample;
        logic [LEVEL_W-1:0]  level;
        logic [DEPTH_W-1:0]  ring_depth;
        logic                mute;
    } bdv_item_t;

    typedef struct packed {
        logic               neg;
        logic [PROD_W-1:0]  mag;
        logic               mute;
        logic               drop;
    } bdv_prod_t;

    typedef struct packed {
        logic [DAC_W-1:0]   dac_word;
        logic               drop_extra;
    } bdv_result_t;

endpackage

@@ rtl/bdv_filter.sv @@
// bdv_filter: held level, DC mean tracker, drop counter and gain multiply.
// Depends on bdv_pkg.
module bdv_filter
    import bdv_pkg::*;
#(
    parameter int DROP_PERIOD = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  bdv_item_t          item,
    input  logic [GAIN_W-1:0]  gain,
    input  logic [DEPTH_W-1:0] deep_threshold,
    output bdv_prod_t          prod_reg
);

    localparam int CNT_W = (DROP_PERIOD > 1) ? $clog2(DROP_PERIOD) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DROP_PERIOD - 1);

    logic [MEAN_W-1:0]  mean_reg, mean_next;
    logic [LEVEL_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    bdv_prod_t          prod_next;

    always_comb
    begin
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] diff_a;
        logic signed [DIFF_W-1:0] sum;
        logic signed [DIFF_W-1:0] diff_b;
        logic signed [DIFF_W-1:0] v_full;
        logic [MAG_W:0]           v9;
        logic [MAG_W-1:0]         mag;
        logic                     drop;

        held_next = item.have_sample ? item.level : held_reg;
        cnt_next  = cnt_reg;
        drop      = 1'b0;
        if (item.have_sample && (item.ring_depth > deep_threshold))
        begin
            if (cnt_reg == CNT_LAST)
            begin
                cnt_next = '0;
                drop     = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        // mean += floor((x - mean) / 2^9); v = floor((x - mean) / 2^8)
        x         = $signed({1'b0, held_next, 8'h00});
        diff_a    = x - $signed({1'b0, mean_reg});
        sum       = $signed({1'b0, mean_reg}) + (diff_a >>> MEAN_SHIFT);
        mean_next = sum[MEAN_W-1:0];
        diff_b    = x - $signed({1'b0, mean_next});
        v_full    = diff_b >>> OUT_SHIFT;
        v9        = v_full[MAG_W:0];
        mag       = v9[MAG_W] ? MAG_W'(-v9) : v9[MAG_W-1:0];

        prod_next.neg  = v9[MAG_W];
        prod_next.mag  = PROD_W'(mag) * PROD_W'(gain);
        prod_next.mute = item.mute;
        prod_next.drop = drop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            held_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            mean_reg <= mean_next;
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

@@ rtl/bdv_scale.sv @@
// bdv_scale: divide by 320, apply sign and mute, offset to midpoint and clamp.
// Depends on bdv_pkg.
module bdv_scale
    import bdv_pkg::*;
(
    input  logic        clk,
    input  logic        take,
    input  bdv_prod_t   prod,
    output bdv_result_t result_reg
);

    bdv_result_t result_next;

    always_comb
    begin
        logic [QUOT0_W-1:0] q0;
        logic [RPROD_W-1:0] rp;
        logic [QUOT_W-1:0]  q;
        logic [LEVEL_W-1:0] d;

        // truncate toward zero on the magnitude: floor(floor(|p| / 64) / 5)
        q0 = prod.mag[PROD_W-1:DIV64_SHIFT];
        rp = RPROD_W'(q0) * RPROD_W'(RECIP_5);
        q  = rp[RPROD_W-1:RECIP_SHIFT];

        if (prod.mute)
            d = MID_LEVEL;
        else if (prod.neg)
            d = (q > NEG_LIMIT) ? '0 : LEVEL_W'(MID_LEVEL - q[LEVEL_W-1:0]);
        else
            d = (q > POS_LIMIT) ? MAX_LEVEL : LEVEL_W'(MID_LEVEL + q[LEVEL_W-1:0]);

        result_next.dac_word   = {d, 8'h00};
        result_next.drop_extra = prod.drop;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

@@ rtl/beeper_dc_block_volume.sv @@
// beeper_dc_block_volume: top level of the beeper DC blocker and volume stage.
// Depends on bdv_pkg, bdv_filter and bdv_scale.
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  tuser: have_sample; tdata: level, ring_depth, mute
//  m_*      out        m_tvalid/m_tready  tdata: dac_word, drop_extra
//  cfg_*    in         cfg_valid/cfg_ready index 0 gain, 1 deep_threshold
//
// One item per cycle sustained while m_tready is not held low; a result reaches the result
// register by way of the input register, filter/multiply and scale/clamp.
// The mean, held level and drop count advance once per item, as the filter takes it.
// Reset clears all valid flags and filter state and loads the register defaults.
// Stages stall independently: a stage takes a new request whenever it is empty
// or its content moves on, so input is accepted while a result waits if a stage is empty.
module beeper_dc_block_volume
    import bdv_pkg::*;
#(
    parameter int DROP_PERIOD = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] level, [19:8] ring_depth, [20] mute
    input  logic                   s_tuser,   // [0] have_sample
    // master stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [15:0] dac_word, [16] drop_extra
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [GAIN_W-1:0]  gain_reg;
    logic [DEPTH_W-1:0] thresh_reg;

    logic        in_valid_reg, prod_valid_reg, out_valid_reg;
    logic        rdy_in, rdy_prod, rdy_out;
    bdv_item_t   item_reg;
    bdv_prod_t   prod_reg;
    bdv_result_t result_reg;

    // Configuration: always ready; to be written only while idle, which goes unchecked
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_THRESH: thresh_reg <= cfg_data[DEPTH_W-1:0];
                default:    ;
            endcase
        end
    end

    // Per-stage ready: empty or draining
    assign rdy_out  = !out_valid_reg  || m_tready;
    assign rdy_prod = !prod_valid_reg || rdy_out;
    assign rdy_in   = !in_valid_reg   || rdy_prod;
    assign s_tready = rdy_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rdy_in)
                in_valid_reg <= s_tvalid;
            if (rdy_prod)
                prod_valid_reg <= in_valid_reg;
            if (rdy_out)
                out_valid_reg <= prod_valid_reg;
        end
    end

    // Input register: capture the request
    always_ff @(posedge clk)
    begin
        if (s_tvalid && rdy_in)
        begin
            item_reg.have_sample <= s_tuser;
            item_reg.level       <= s_tdata[7:0];
            item_reg.ring_depth  <= s_tdata[19:8];
            item_reg.mute        <= s_tdata[20];
        end
    end

    bdv_filter #(
        .DROP_PERIOD (DROP_PERIOD)
    ) u_filter (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (in_valid_reg && rdy_prod),
        .item           (item_reg),
        .gain           (gain_reg),
        .deep_threshold (thresh_reg),
        .prod_reg       (prod_reg)
    );

    bdv_scale u_scale (
        .clk        (clk),
        .take       (prod_valid_reg && rdy_out),
        .prod       (prod_reg),
        .result_reg (result_reg)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, result_reg.drop_extra, result_reg.dac_word};

endmodule

@@ rtl/bdv_checker.sv @@
// bdv_checker: port-level assertions for beeper_dc_block_volume, and its bind.
// Depends on bdv_pkg.
module bdv_checker
    import bdv_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic last_drop_reg;

    // Remember drop_extra of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_drop_reg <= 1'b0;
        else if (m_tvalid && m_tready)
            last_drop_reg <= m_tdata[16];
    end

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_double_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tdata[16]) |-> !last_drop_reg)
        else $error("drop requested on two results in a row");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind beeper_dc_block_volume bdv_checker u_bdv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for beeper_dc_block_volume, the beeper DC blocker and
// volume stage. Depends on bdv_pkg and the block's RTL; predicts every result with an
// in-bench model of the filter, volume scaling, clamp and sample-drop counter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdv_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int DROP_PERIOD  = 32;
    localparam int VOL_DEN      = 320;      // volume is gain / VOL_DEN
    localparam int DEPTH_MAX    = (1 << DEPTH_W) - 1;
    localparam int RAND_ITEMS   = 225;      // random requests per phase
    localparam int LONG_STALL   = 300;      // cycles the sink holds off under pressure
    localparam int TAIL_CYCLES  = 12;       // idle tail after the final drain of the three-stage pipeline
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    beeper_dc_block_volume #(
        .DROP_PERIOD (DROP_PERIOD)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] level, [19:8] ring_depth, [20] mute
        .s_tuser   (s_tuser),     // [0] have_sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [15:0] dac_word, [16] drop_extra
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Filter model state and register copies, as they stand after reset
    // ------------------------------------------------------------------
    int                 mean_est = 0;       // DC estimate, 8.8 fixed point
    logic [LEVEL_W-1:0] held_lvl = '0;      // last level delivered by the ring
    int                 drop_cnt = 0;       // popped samples taken while deep
    logic [GAIN_W-1:0]  gain_cur = GAIN_RESET;
    logic [DEPTH_W-1:0] thr_cur  = THRESH_RESET;

    bdv_item_t   pending_req[$];    // requests waiting for the driver
    bdv_result_t dac_expect[$];     // predicted results, oldest first

    // Phase controls, written by the sequencer with nonblocking assignments only
    bit src_gappy  = 1'b0;
    bit snk_gappy  = 1'b0;
    int stall_trig = 0;

    int mism = 0;
    int cycle_cnt = 0;

    // Advance the model by one request and return the result it produces.
    function automatic bdv_result_t volume_predict(bdv_item_t it);
        bdv_result_t r;
        int x;
        int v;
        int d;
        r.drop_extra = 1'b0;
        if (it.have_sample) begin
            held_lvl = it.level;
            // Only popped samples on a deep ring advance the drop counter
            if (it.ring_depth > thr_cur) begin
                drop_cnt++;
                if (drop_cnt >= DROP_PERIOD) begin
                    drop_cnt = 0;
                    r.drop_extra = 1'b1;
                end
            end
        end
        x = int'(held_lvl) << OUT_SHIFT;
        // Arithmetic shifts on a signed int floor toward minus infinity
        mean_est += (x - mean_est) >>> MEAN_SHIFT;
        v = (x - mean_est) >>> OUT_SHIFT;
        v = (v * int'(gain_cur)) / VOL_DEN;     // truncates toward zero
        if (it.mute)
            v = 0;
        d = int'(MID_LEVEL) + v;
        if (d < 0)
            d = 0;
        if (d > int'(MAX_LEVEL))
            d = int'(MAX_LEVEL);
        r.dac_word = {d[LEVEL_W-1:0], 8'h00};
        return r;
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_gap(bit enabled);
        int sel;
        if (!enabled)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return 0;
        if (sel < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued requests, predict each one on acceptance
    // ------------------------------------------------------------------
    bdv_item_t offered;
    int        src_gap = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            src_gap  = 0;
        end else begin
            if (s_tvalid && s_tready)
                dac_expect.push_back(volume_predict(offered));
            // Hold the current request until it is taken
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_req.size() != 0) begin
                    offered  = pending_req.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'({offered.mute, offered.ring_depth,
                                            offered.level});
                    s_tuser  <= offered.have_sample;
                    src_gap  = pick_gap(src_gappy);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every accepted result, throttle m_tready
    // ------------------------------------------------------------------
    bdv_result_t         want;
    logic [DAC_W-1:0]    got_word;
    logic                got_drop;
    int                  snk_hold = 0;
    int                  stall_seen = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_word = m_tdata[DAC_W-1:0];
                got_drop = m_tdata[DAC_W];
                if (dac_expect.size() == 0) begin
                    mism++;
                    if (mism <= MAX_REPORTS)
                        $display("unexpected result: dac_word=%h drop_extra=%b",
                                 got_word, got_drop);
                end else begin
                    want = dac_expect.pop_front();
                    if (got_word !== want.dac_word || got_drop !== want.drop_extra) begin
                        mism++;
                        if (mism <= MAX_REPORTS)
                            $display("mismatch: dac_word exp %h got %h, drop_extra exp %b got %b",
                                     want.dac_word, got_word, want.drop_extra, got_drop);
                    end
                end
            end
            // A new trigger starts a long hold-off so the pipeline backs up
            if (stall_trig != stall_seen) begin
                stall_seen = stall_trig;
                snk_hold   = LONG_STALL;
            end
            if (snk_hold > 0) begin
                snk_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                snk_hold = pick_gap(snk_gappy);
            end
        end
    end

    // Bound the run; a hang ends as a failure
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    function automatic void add_item(logic have, logic [LEVEL_W-1:0] lvl,
                                     logic [DEPTH_W-1:0] depth, logic mute);
        bdv_item_t it;
        it.have_sample = have;
        it.level       = lvl;
        it.ring_depth  = depth;
        it.mute        = mute;
        pending_req.push_back(it);
    endfunction

    // Depth mostly hugs the threshold or sits above it, so dropping is exercised.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        int sel;
        int d;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            d = int'(thr_cur) + int'($urandom_range(0, 6)) - 3;
        else if (sel < 7)
            d = $urandom_range(int'(thr_cur), DEPTH_MAX);
        else
            d = $urandom_range(0, DEPTH_MAX);
        if (d < 0)
            d = 0;
        if (d > DEPTH_MAX)
            d = DEPTH_MAX;
        return d[DEPTH_W-1:0];
    endfunction

    // Queue beeper-like bursts: flat runs, square waves and some raw noise.
    task automatic queue_random(input int n);
        int made;
        int kind;
        int run;
        int half;
        int i;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
        logic [LEVEL_W-1:0] lvl;
        logic have;
        made = 0;
        while (made < n) begin
            kind = $urandom_range(0, 3);
            run  = $urandom_range(1, 48);
            half = $urandom_range(1, 8);
            lo   = LEVEL_W'($urandom);
            hi   = LEVEL_W'($urandom);
            if (kind == 0 || ($urandom_range(0, 1) == 0 && kind == 2)) begin
                lo = '0;
                hi = '1;
            end
            if (kind == 0 && $urandom_range(0, 1) == 1)
                lo = hi;
            for (i = 0; i < run && made < n; i++) begin
                case (kind)
                    0, 1:    lvl = lo;
                    2:       lvl = ((i / half) % 2) ? hi : lo;
                    default: lvl = LEVEL_W'($urandom);
                endcase
                if (kind == 3)
                    have = ($urandom_range(0, 1) == 1);
                else
                    have = ($urandom_range(0, 7) != 0);
                // Level is ignored without a sample; scramble it then
                add_item(have, have ? lvl : LEVEL_W'($urandom), pick_depth(),
                         $urandom_range(0, 9) == 0);
                made++;
            end
        end
    endtask

    // Wait until every request has been taken and every result has come back.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_req.size() != 0 || s_tvalid || dac_expect.size() != 0)
            @(negedge clk);
    endtask

    // Write one register while the block is idle; update the model on the handshake.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_GAIN)
            gain_cur = GAIN_W'(val);
        else
            thr_cur = DEPTH_W'(val);
    endtask

    // One configuration phase: set registers, pick idling, run random bursts.
    task automatic run_phase(input int unsigned gain, input int unsigned thr,
                             input bit src_gaps, input bit snk_gaps,
                             input bit hold_sink, input bit pause_mid);
        write_reg(REG_GAIN, gain);
        write_reg(REG_THRESH, thr);
        @(negedge clk);
        src_gappy <= src_gaps;
        snk_gappy <= snk_gaps;
        if (hold_sink)
            stall_trig <= stall_trig + 1;
        if (pause_mid) begin
            // Drain completely halfway through before offering the rest
            queue_random(RAND_ITEMS / 2);
            wait_idle();
            queue_random(RAND_ITEMS - RAND_ITEMS / 2);
        end else begin
            queue_random(RAND_ITEMS);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset register values.
        // No sample yet: the held zero feeds the filter and the level is ignored
        add_item(1'b0, 8'hFF, 12'h000, 1'b0);
        // Full-scale step on a full ring, then just above and exactly at threshold
        add_item(1'b1, 8'hFF, 12'hFFF, 1'b0);
        add_item(1'b1, 8'hFF, THRESH_RESET + 12'd1, 1'b0);
        add_item(1'b1, 8'hFF, THRESH_RESET, 1'b0);
        // Empty ring while deep: hold the level, leave the drop counter alone
        add_item(1'b0, 8'h00, 12'hFFF, 1'b0);
        // Step to zero swings the output just below the midpoint
        add_item(1'b1, 8'h00, 12'h000, 1'b0);
        // Muted: midpoint out, filter keeps moving
        add_item(1'b1, 8'h00, 12'h000, 1'b1);
        add_item(1'b0, 8'hAA, 12'h555, 1'b1);
        add_item(1'b1, 8'hAA, 12'hAAA, 1'b0);
        add_item(1'b1, 8'h55, 12'h555, 1'b0);
        add_item(1'b1, 8'h80, 12'h7FF, 1'b1);
        // Square wave on a deep ring advances the drop counter every sample
        for (k = 0; k < 12; k++)
            add_item(1'b1, (k % 2) ? 8'h00 : 8'hFF, 12'hFFF, 1'b0);
        wait_idle();

        // Extremes first: no volume with the threshold at zero, under a long sink stall
        run_phase(0, 0, 1'b0, 1'b0, 1'b1, 1'b0);
        // Gain beyond unity saturates in the clamp; the ring is never deep
        run_phase((1 << GAIN_W) - 1, DEPTH_MAX, 1'b1, 1'b1, 1'b0, 1'b0);
        // Back to the reset values, sender pauses midway for a full drain
        run_phase(GAIN_RESET, THRESH_RESET, 1'b1, 1'b0, 1'b0, 1'b1);
        run_phase(1, 2048, 1'b0, 1'b1, 1'b0, 1'b0);
        run_phase($urandom_range(2, VOL_DEN - 1), $urandom_range(1, DEPTH_MAX - 1),
                  1'b1, 1'b1, 1'b0, 1'b0);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mism == 0 && dac_expect.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bdv_pkg.sv
rtl/bdv_filter.sv
rtl/bdv_scale.sv
rtl/beeper_dc_block_volume.sv
rtl/bdv_checker.sv
tb/tb_top.sv
